// File: rtl/sbrm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the smoothed byte rate meter.
// No dependencies; compiled first.
package sbrm_pkg;

  localparam int TICK_W = 32;   // time stamp width
  localparam int BYTE_W = 64;   // byte counter width
  localparam int RATE_W = 48;   // rate width, also quotient bits
  localparam int PROD_W = 96;   // byte difference times ticks per second
  localparam int DEN_W  = 52;   // elapsed ticks times one million
  localparam int REM_W  = DEN_W + 1;

  localparam logic [TICK_W-1:0] MICRO_DIV = 32'd1000000;
  localparam logic [TICK_W-1:0] TPS_RESET = 32'd1000;
  localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_DEN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_AVG,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic done;  // one-cycle pulse, quotient or saturation valid
    logic sat;   // quotient does not fit in RATE_W bits
  } div_stat_t;

endpackage

// File: rtl/sbrm_if.sv
`timescale 1ns / 1ps
// Valid/ready channels for samples and rate results.
// Depends on sbrm_pkg.
interface sbrm_sample_if;
  import sbrm_pkg::*;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] now_ticks;
  logic [BYTE_W-1:0] total_bytes;
  modport source (output valid, output now_ticks, output total_bytes, input ready);
  modport sink   (input valid, input now_ticks, input total_bytes, output ready);
endinterface

interface sbrm_rate_if;
  import sbrm_pkg::*;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate_mbps;
  modport source (output valid, output rate_mbps, input ready);
  modport sink   (input valid, input rate_mbps, output ready);
endinterface

// File: rtl/sbrm_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, with an up-front overflow check.
// Depends on sbrm_pkg.
module sbrm_divider #(
  parameter int TOP_W = 67
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [TOP_W-1:0]           num_top,
  input  logic [sbrm_pkg::RATE_W-1:0] num_low,
  input  logic [sbrm_pkg::DEN_W-1:0] den,
  output logic [sbrm_pkg::RATE_W-1:0] quot,
  output sbrm_pkg::div_stat_t        stat
);
  import sbrm_pkg::*;

  localparam int CMP_W = (TOP_W > REM_W) ? TOP_W : REM_W;
  localparam int CNT_W = $clog2(RATE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RATE_W - 1);

  logic [REM_W-1:0]  rem;
  logic [RATE_W-1:0] low;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  logic [CMP_W-1:0] top_ext;
  logic [CMP_W-1:0] den_ext;
  logic [REM_W-1:0] trial;
  logic             ge;

  assign top_ext = CMP_W'(num_top);
  assign den_ext = CMP_W'(den);
  assign trial   = {rem[REM_W-2:0], low[RATE_W-1]};
  assign ge      = trial >= {1'b0, den};
  assign quot    = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        if (top_ext >= den_ext) begin
          // quotient reaches 2^RATE_W
          stat.done <= 1'b1;
          stat.sat  <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= '0;
        end
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy      <= 1'b0;
          stat.done <= 1'b1;
          stat.sat  <= 1'b0;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= top_ext[REM_W-1:0];
      low <= num_low;
    end else if (busy) begin
      rem <= ge ? (trial - {1'b0, den}) : trial;
      low <= {low[RATE_W-2:0], ge};
    end
  end

endmodule

// File: rtl/smoothed_byte_rate_meter.sv
`timescale 1ns / 1ps
// Smoothed byte rate meter, top level: sequencer, shared multiplier, state.
// Depends on sbrm_pkg, sbrm_if.sv and sbrm_divider.
//
//  channel   dir  beat payload                         notes
//  sample    in   now_ticks[31:0], total_bytes[63:0]    one beat per result
//  result    out  rate_mbps[47:0]                       Mbit/s, FRAC_BITS fraction
//  cfg       in   cfg_we, cfg_wdata[31:0]               ticks_per_second
//
// A first sample or one too close to the last recorded one goes straight to output.
// A measured sample takes three passes through the shared 32x32 multiplier,
// then a state to start the bit-serial divider and a wait on it for all
// 48 quotient bits, then averaging and output load. A quotient that
// overflows is caught at start. Zero elapsed ticks skips the divider.
// rst is synchronous; it restores ticks_per_second to 1000 and clears state.
// The output register lets a result wait while the next sample is taken;
// a finished result stalls in ST_OUT only if the previous one is still held.
module smoothed_byte_rate_meter #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [sbrm_pkg::TICK_W-1:0] cfg_wdata,
  sbrm_sample_if.sink               sample,
  sbrm_rate_if.source               result
);
  import sbrm_pkg::*;

  // numerator = product << (3 + FRAC_BITS): the 3 is the bits-per-byte factor
  localparam int SH_W  = 3 + FRAC_BITS;
  localparam int NUM_W = PROD_W + SH_W;
  localparam int TOP_W = NUM_W - RATE_W;

  state_t state, state_next;

  // configuration and architectural state
  logic [TICK_W-1:0] tps;
  logic              started;
  logic [TICK_W-1:0] last_time;
  logic [BYTE_W-1:0] last_count;
  logic [RATE_W-1:0] last_rate;

  // working registers
  logic [TICK_W-1:0]   dt;
  logic [BYTE_W-1:0]   dbytes;
  logic [2*TICK_W-1:0] mul_p;
  logic [PROD_W-1:0]   prod_acc;
  logic [RATE_W-1:0]   fresh;
  logic [RATE_W-1:0]   res;

  // output stage
  logic              out_valid;
  logic [RATE_W-1:0] out_rate;

  logic [TICK_W-1:0] mul_a;
  logic [TICK_W-1:0] mul_b;
  logic [TICK_W-1:0] dt_now;
  logic              accept;
  logic              too_close;
  logic              out_load;
  logic              div_start;
  logic [NUM_W-1:0]  num;
  logic [RATE_W:0]   avg_sum;
  logic [RATE_W-1:0] quot;
  div_stat_t         dstat;

  assign sample.ready     = (state == ST_IDLE);
  assign accept           = sample.valid && sample.ready;
  assign dt_now           = sample.now_ticks - last_time;   // wraps mod 2^32
  assign too_close        = dt_now < tps;
  assign out_load         = (state == ST_OUT) && (!out_valid || result.ready);
  assign result.valid     = out_valid;
  assign result.rate_mbps = out_rate;
  assign num              = {prod_acc, {SH_W{1'b0}}};
  assign avg_sum          = {1'b0, fresh} + {1'b0, last_rate};

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!started || too_close) state_next = ST_OUT;
          else                       state_next = ST_MUL_LO;
        end
      end
      ST_MUL_LO:    state_next = ST_MUL_HI;
      ST_MUL_HI:    state_next = ST_MUL_DEN;
      ST_MUL_DEN:   state_next = ST_DIV_START;
      // zero elapsed ticks means a zero divisor: the new rate is zero
      ST_DIV_START: state_next = (dt == '0) ? ST_AVG : ST_DIV_WAIT;
      ST_DIV_WAIT:  if (dstat.done) state_next = ST_AVG;
      ST_AVG:       state_next = ST_OUT;
      ST_OUT:       if (out_load) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // ---------------- sequencer outputs ----------------
  always_comb begin
    mul_a     = '0;
    mul_b     = tps;
    div_start = 1'b0;
    unique case (state)
      ST_MUL_LO:  mul_a = dbytes[TICK_W-1:0];
      ST_MUL_HI:  mul_a = dbytes[BYTE_W-1:TICK_W];
      ST_MUL_DEN: begin
        mul_a = dt;
        mul_b = MICRO_DIV;
      end
      ST_DIV_START: div_start = (dt != '0);
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // ---------------- control and state registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      tps        <= TPS_RESET;
      started    <= 1'b0;
      last_time  <= '0;
      last_count <= '0;
      last_rate  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) tps <= cfg_wdata;
      if (accept && (!started || !too_close)) begin
        started    <= 1'b1;
        last_time  <= sample.now_ticks;
        last_count <= sample.total_bytes;
      end
      if (state == ST_AVG) last_rate <= avg_sum[RATE_W:1];
      if (out_load)                      out_valid <= 1'b1;
      else if (result.ready)             out_valid <= 1'b0;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      dt     <= dt_now;
      dbytes <= sample.total_bytes - last_count;   // wraps mod 2^64
      res    <= started ? last_rate : '0;
    end
    // shared multiplier, registered
    if (state == ST_MUL_LO || state == ST_MUL_HI || state == ST_MUL_DEN)
      mul_p <= mul_a * mul_b;
    if (state == ST_MUL_HI)  prod_acc <= PROD_W'(mul_p);
    if (state == ST_MUL_DEN) prod_acc <= prod_acc + {mul_p, {TICK_W{1'b0}}};
    if (state == ST_DIV_START) fresh <= '0;
    if (state == ST_DIV_WAIT && dstat.done) fresh <= dstat.sat ? RATE_MAX : quot;
    if (state == ST_AVG) res <= avg_sum[RATE_W:1];
    if (out_load) out_rate <= res;
  end

  sbrm_divider #(
    .TOP_W (TOP_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num_top (num[NUM_W-1:RATE_W]),
    .num_low (num[RATE_W-1:0]),
    .den     (mul_p[DEN_W-1:0]),
    .quot    (quot),
    .stat    (dstat)
  );

endmodule
